// ===== rtl/fta_pkg.sv =====
// Package for the fork table arbiter: sizes, event kinds, the command and status
// structs between controller and datapath, and the ring-neighbour helper functions.
// Depends on nothing.
package fta_pkg;

  localparam int NUM_REQUESTERS = 5;
  localparam int IDX_W          = 5;
  localparam int KIND_W         = 2;
  localparam int CAND_W         = $clog2(NUM_REQUESTERS);
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [IDX_W:0] REQ_LIMIT = (IDX_W + 1)'(NUM_REQUESTERS);
  localparam logic [CAND_W-1:0] CAND_MAX = CAND_W'(NUM_REQUESTERS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_HUNGRY = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_TOGGLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic take;
    logic decode;
    logic check;
    logic finish;
  } fta_cmd_t;

  typedef struct packed {
    logic need_check;
    logic cand_last;
    logic stall;
    logic out_free;
  } fta_sts_t;

  function automatic logic [CAND_W-1:0] left_of(input logic [CAND_W-1:0] i);
    return (i == CAND_MAX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [CAND_W-1:0] right_of(input logic [CAND_W-1:0] i);
    return (i == '0) ? CAND_MAX : i - 1'b1;
  endfunction

  function automatic logic [NUM_REQUESTERS-1:0] pair_mask(input logic [CAND_W-1:0] i);
    logic [NUM_REQUESTERS-1:0] m;
    m = '0;
    m[i] = 1'b1;
    m[left_of(i)] = 1'b1;
    return m;
  endfunction

endpackage

// ===== rtl/fta_dp.sv =====
// Datapath of the fork table arbiter: fork and hungry bits, paused flag, candidate
// scan, pending grant and the output register. Depends on fta_pkg; driven by fta_ctrl.
module fta_dp
  import fta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  fta_cmd_t               cmd,
  output fta_sts_t               sts,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [IDX_W-1:0]       in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_grant_valid,
  output logic [IDX_W-1:0]       out_granted,
  output logic                   out_error,
  output logic                   out_last
);

  logic [NUM_REQUESTERS-1:0] fork_busy_r, fork_busy_nxt;
  logic [NUM_REQUESTERS-1:0] hungry_r, hungry_nxt;
  logic                      paused_r, paused_nxt;
  logic [KIND_W-1:0]         item_kind_r;
  logic [IDX_W-1:0]          item_req_r;
  logic                      err_r, err_nxt;
  logic [CAND_W-1:0]         cand_r, cand_nxt;
  logic                      scan_r, scan_nxt;
  logic                      second_r, second_nxt;
  logic [CAND_W-1:0]         pend_r, pend_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_gv_r, out_gv_nxt;
  logic [IDX_W-1:0]          out_granted_r, out_granted_nxt;
  logic                      out_err_r, out_err_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [CAND_W-1:0]         idx;
  logic                      in_range;
  logic                      dup;
  logic                      dec_err;
  logic                      hit;
  logic                      load;

  assign idx      = item_req_r[CAND_W-1:0];
  assign in_range = {1'b0, item_req_r} < REQ_LIMIT;
  assign dup      = (item_kind_r == KIND_HUNGRY) && in_range && hungry_r[idx];
  assign dec_err  = ((item_kind_r == KIND_HUNGRY) || (item_kind_r == KIND_DONE)) &&
                    (!in_range || dup);
  assign hit      = hungry_r[cand_r] && ((fork_busy_r & pair_mask(cand_r)) == '0);

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.stall      = hit && pend_v_r && !sts.out_free;
  assign sts.cand_last  = scan_r ? (cand_r == CAND_MAX) : second_r;
  assign sts.need_check = !dec_err &&
                          (((item_kind_r == KIND_DONE) && !paused_r) ||
                           ((item_kind_r == KIND_TOGGLE) && paused_r));

  always_comb begin
    fork_busy_nxt   = fork_busy_r;
    hungry_nxt      = hungry_r;
    paused_nxt      = paused_r;
    err_nxt         = err_r;
    cand_nxt        = cand_r;
    scan_nxt        = scan_r;
    second_nxt      = second_r;
    pend_nxt        = pend_r;
    pend_v_nxt      = pend_v_r;
    load            = 1'b0;
    out_gv_nxt      = out_gv_r;
    out_granted_nxt = out_granted_r;
    out_err_nxt     = out_err_r;
    out_last_nxt    = out_last_r;

    if (cmd.decode) begin
      err_nxt    = dec_err;
      pend_v_nxt = 1'b0;
      if (!dec_err) begin
        case (item_kind_r)
          KIND_HUNGRY: begin
            if (!paused_r && ((fork_busy_r & pair_mask(idx)) == '0)) begin
              fork_busy_nxt = fork_busy_r | pair_mask(idx);
              pend_nxt      = idx;
              pend_v_nxt    = 1'b1;
            end else begin
              hungry_nxt[idx] = 1'b1;
            end
          end
          KIND_DONE: begin
            fork_busy_nxt = fork_busy_r & ~pair_mask(idx);
            cand_nxt      = right_of(idx);
            scan_nxt      = 1'b0;
            second_nxt    = 1'b0;
          end
          KIND_TOGGLE: begin
            paused_nxt = !paused_r;
            cand_nxt   = '0;
            scan_nxt   = 1'b1;
            second_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.check) begin
      if (hit) begin
        fork_busy_nxt      = fork_busy_r | pair_mask(cand_r);
        hungry_nxt[cand_r] = 1'b0;
        pend_nxt           = cand_r;
        pend_v_nxt         = 1'b1;
        if (pend_v_r) begin
          load            = 1'b1;
          out_gv_nxt      = 1'b1;
          out_granted_nxt = IDX_W'(pend_r);
          out_err_nxt     = 1'b0;
          out_last_nxt    = 1'b0;
        end
      end
      if (scan_r) begin
        cand_nxt = cand_r + 1'b1;
      end else begin
        cand_nxt   = left_of(left_of(cand_r));
        second_nxt = 1'b1;
      end
    end

    if (cmd.finish) begin
      load            = 1'b1;
      out_gv_nxt      = pend_v_r;
      out_granted_nxt = pend_v_r ? IDX_W'(pend_r) : '0;
      out_err_nxt     = pend_v_r ? 1'b0 : err_r;
      out_last_nxt    = 1'b1;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fork_busy_r <= '0;
      hungry_r    <= '0;
      paused_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      scan_r      <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      fork_busy_r <= fork_busy_nxt;
      hungry_r    <= hungry_nxt;
      paused_r    <= paused_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      scan_r      <= scan_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_kind_r <= in_kind;
      item_req_r  <= in_req;
    end
    cand_r        <= cand_nxt;
    pend_r        <= pend_nxt;
    out_gv_r      <= out_gv_nxt;
    out_granted_r <= out_granted_nxt;
    out_err_r     <= out_err_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_grant_valid = out_gv_r;
  assign out_granted     = out_granted_r;
  assign out_error       = out_err_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_no_check_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.check && sts.stall))
    else $error("Candidate checked while a pending grant could not be sent.");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> sts.out_free)
    else $error("Output register overwritten before its transfer.");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decode && dec_err) |=> ($stable(fork_busy_r) && $stable(hungry_r)))
    else $error("Rejected event changed the fork or hungry state.");

  a_grant_takes_forks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && hit) |=>
      ((fork_busy_r & pair_mask($past(cand_r))) == pair_mask($past(cand_r))))
    else $error("Granted requester does not hold both forks.");
`endif

endmodule

// ===== rtl/fta_ctrl.sv =====
// Controller of the fork table arbiter: sequences accept, decode, candidate checks
// and the final result. Depends on fta_pkg; commands fta_dp.
module fta_ctrl
  import fta_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fta_sts_t sts,
  output fta_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.need_check ? S_CHECK : S_FINISH;
      end
      S_CHECK: begin
        if (!sts.stall) begin
          cmd.check = 1'b1;
          if (sts.cand_last) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == S_DECODE))
    else $error("Accepted event did not move to decode.");

  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("Controller not ready after the final result.");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.decode, cmd.check, cmd.finish}))
    else $error("More than one command issued in a cycle.");
`endif

endmodule

// ===== rtl/fork_table_arbiter.sv =====
// Top level of the fork table arbiter: ring of NUM_REQUESTERS requesters sharing forks.
// Depends on fta_pkg, fta_ctrl and fta_dp.
//
// The input stream carries one event per transfer: in_tuser holds the kind (hungry,
// done, pause/resume toggle) and in_tdata the requester index. The output stream
// returns one or more results per event, the final one marked by out_tlast; a result
// is a grant (requester index) or a plain acknowledgement, with an error flag for an
// index out of range or a repeated hungry request.
// An event is taken, and decoded in the cycle after. A done event while serving
// then checks its right and left neighbours in that order; a resume checks every
// requester from index 0 upward. A final step loads the last result once the
// output register is free. The first result appears in the cycle after it is loaded.
// Reset frees all forks, clears all hungry marks and leaves the block serving.
// A stalled receiver holds the single output register; the block waits until the
// result has been taken before it loads the next one, and takes no new event meanwhile.
module fork_table_arbiter
  import fta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] requester, [7:5] zero
  input  logic [KIND_W-1:0]      in_tuser,   // [1:0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] grant_valid, [5:1] granted, [6] error
  output logic                   out_tlast
);

  fta_cmd_t         cmd;
  fta_sts_t         sts;
  logic             grant_valid;
  logic [IDX_W-1:0] granted;
  logic             error_flag;

  fta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fta_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_tuser),
    .in_req          (in_tdata[IDX_W-1:0]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_grant_valid (grant_valid),
    .out_granted     (granted),
    .out_error       (error_flag),
    .out_last        (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - IDX_W - 2){1'b0}}, error_flag, granted, grant_valid};

endmodule
